### src/ring_buffer_deque_unit_macros.svh
// Assertion macros used by the ring buffer deque sequencer
`ifndef RING_BUFFER_DEQUE_UNIT_MACROS_SVH
`define RING_BUFFER_DEQUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define RBD_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("rbd assertion failed");
// next-cycle implication, disabled while in reset
`define RBD_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("rbd assertion failed");
`else
`define RBD_ASSERT_NOW(label, trig, cond)
`define RBD_ASSERT_NEXT(label, trig, cond)
`endif

`endif

### src/rbd_pkg.sv
// Types and constants of the ring buffer deque
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int unsigned OPCODE_W   = 4;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MAXLEN_W   = 7;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 7'd64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND    = 4'd0,
    OP_PREPEND   = 4'd1,
    OP_POP_RIGHT = 4'd2,
    OP_POP_LEFT  = 4'd3,
    OP_GET       = 4'd4,
    OP_SET       = 4'd5,
    OP_DELETE    = 4'd6,
    OP_REVERSE   = 4'd7,
    OP_CLEAR     = 4'd8
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_ENABLE = 1'd0,
    REG_MAX_LENGTH   = 1'd1
  } reg_idx_e;

  typedef struct packed {
    logic                limit_enable;
    logic [MAXLEN_W-1:0] max_length;
  } cfg_t;

endpackage

### src/rbd_if.sv
// Request and response channel interfaces of the ring buffer deque
`timescale 1ns / 1ps
interface rbd_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                                valid;
  logic                                ready;
  logic [rbd_pkg::OPCODE_W-1:0]        opcode;
  logic signed [rbd_pkg::POS_W-1:0]    position;
  logic [DATA_WIDTH-1:0]               data_in;

  modport source (output valid, opcode, position, data_in, input ready);
  modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

interface rbd_out_if #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned OCC_WIDTH  = 7
);
  logic                         valid;
  logic                         ready;
  logic [DATA_WIDTH-1:0]        data_out;
  logic [rbd_pkg::STATUS_W-1:0] status;
  logic [OCC_WIDTH-1:0]         occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

### src/rbd_mem.sv
// Single-port ring store with registered read data
`timescale 1ns / 1ps
module rbd_mem #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rbd_agu.sv
// Shared address unit: head plus logical offset, wrapped into the ring
`timescale 1ns / 1ps
module rbd_agu #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic [AW-1:0] base_i,
  input  logic [CW-1:0] offset_i,
  output logic [AW-1:0] addr_o
);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  // base < DEPTH and offset <= DEPTH, so one subtract is enough
  always_comb begin
    sum     = (CW + 1)'(base_i) + (CW + 1)'(offset_i);
    wrapped = (sum >= (CW + 1)'(DEPTH)) ? sum - (CW + 1)'(DEPTH) : sum;
  end

  assign addr_o = wrapped[AW-1:0];

endmodule

### src/rbd_ctrl.sv
// Operation sequencer: decodes an item and walks the ring store through the address unit
`timescale 1ns / 1ps
`include "ring_buffer_deque_unit_macros.svh"
module rbd_ctrl #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rbd_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rbd_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic signed [rbd_pkg::POS_W-1:0] position_i,
  input  logic [DATA_WIDTH-1:0]            data_in_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [DATA_WIDTH-1:0]            res_data_o,
  output logic [rbd_pkg::STATUS_W-1:0]     res_status_o,
  output logic [CW-1:0]                    res_occ_o,
  output logic                             mem_we_o,
  output logic                             mem_re_o,
  output logic [AW-1:0]                    mem_addr_o,
  output logic [DATA_WIDTH-1:0]            mem_wdata_o,
  input  logic [DATA_WIDTH-1:0]            mem_rdata_i
);

  localparam int unsigned LW = (CW > rbd_pkg::MAXLEN_W) ? CW : rbd_pkg::MAXLEN_W;
  localparam int unsigned SW = ((CW > rbd_pkg::POS_W) ? CW : rbd_pkg::POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_RD_WAIT,
    S_DEL_RD,
    S_DEL_WR,
    S_RV_RDA,
    S_RV_RDB,
    S_RV_WRA,
    S_RV_WRB,
    S_DONE
  } state_e;

  state_e                           st_q, st_d;
  logic [AW-1:0]                    head_q, head_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [rbd_pkg::OPCODE_W-1:0]     op_q, op_d;
  logic signed [rbd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [DATA_WIDTH-1:0]            wdata_q, wdata_d;
  logic [DATA_WIDTH-1:0]            dout_q, dout_d;
  rbd_pkg::status_e                 status_q, status_d;
  logic [CW-1:0]                    idx_a_q, idx_a_d;
  logic [CW-1:0]                    idx_b_q, idx_b_d;
  logic [DATA_WIDTH-1:0]            tmp_q, tmp_d;

  logic [CW-1:0]        agu_off;
  logic [AW-1:0]        agu_addr;
  logic signed [SW-1:0] pos_ext;
  logic signed [SW-1:0] cnt_ext;
  logic signed [SW-1:0] li_full;
  logic [CW-1:0]        li;
  logic                 pos_ok;
  logic                 at_limit;
  logic                 full;
  logic                 empty;

  rbd_agu #(
    .DEPTH (DEPTH)
  ) u_agu (
    .base_i   (head_q),
    .offset_i (agu_off),
    .addr_o   (agu_addr)
  );

  // position check and logical index, negative positions count back from the tail
  always_comb begin
    pos_ext  = SW'(pos_q);
    cnt_ext  = signed'(SW'(count_q));
    pos_ok   = (pos_ext < cnt_ext) && (pos_ext >= -cnt_ext);
    li_full  = pos_q[rbd_pkg::POS_W-1] ? pos_ext + cnt_ext : pos_ext;
    li       = li_full[CW-1:0];
    full     = (count_q == CW'(DEPTH));
    empty    = (count_q == '0);
    // count >= min(max_length, DEPTH)
    at_limit = cfg_i.limit_enable &&
               ((LW'(count_q) >= LW'(cfg_i.max_length)) || full);
  end

  always_comb begin
    st_d        = st_q;
    head_d      = head_q;
    count_d     = count_q;
    op_d        = op_q;
    pos_d       = pos_q;
    wdata_d     = wdata_q;
    dout_d      = dout_q;
    status_d    = status_q;
    idx_a_d     = idx_a_q;
    idx_b_d     = idx_b_q;
    tmp_d       = tmp_q;
    agu_off     = '0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_wdata_o = wdata_q;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = opcode_i;
          pos_d    = position_i;
          wdata_d  = data_in_i;
          dout_d   = '0;
          status_d = rbd_pkg::ST_OK;
          st_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d = S_DONE;
        case (op_q)
          rbd_pkg::OP_APPEND: begin
            if (at_limit) begin
              // drop the head element, then write just past the old tail
              if (!empty) begin
                agu_off = CW'(1);
                head_d  = agu_addr;
                idx_a_d = count_q - CW'(1);
                st_d    = S_WRITE;
              end
            end else if (full) begin
              status_d = rbd_pkg::ST_FULL;
            end else begin
              idx_a_d = count_q;
              count_d = count_q + CW'(1);
              st_d    = S_WRITE;
            end
          end
          rbd_pkg::OP_PREPEND: begin
            if (at_limit && empty) begin
              st_d = S_DONE;
            end else if (!at_limit && full) begin
              status_d = rbd_pkg::ST_FULL;
            end else begin
              // tail element is lost implicitly when at the limit
              agu_off = CW'(DEPTH - 1);
              head_d  = agu_addr;
              idx_a_d = '0;
              if (!at_limit) begin
                count_d = count_q + CW'(1);
              end
              st_d = S_WRITE;
            end
          end
          rbd_pkg::OP_POP_RIGHT: begin
            if (empty) begin
              status_d = rbd_pkg::ST_EMPTY;
            end else begin
              agu_off  = count_q - CW'(1);
              mem_re_o = 1'b1;
              count_d  = count_q - CW'(1);
              st_d     = S_RD_WAIT;
            end
          end
          rbd_pkg::OP_POP_LEFT: begin
            if (empty) begin
              status_d = rbd_pkg::ST_EMPTY;
            end else begin
              agu_off  = '0;
              mem_re_o = 1'b1;
              count_d  = count_q - CW'(1);
              st_d     = S_RD_WAIT;
            end
          end
          rbd_pkg::OP_GET: begin
            if (!pos_ok) begin
              status_d = rbd_pkg::ST_RANGE;
            end else begin
              agu_off  = li;
              mem_re_o = 1'b1;
              st_d     = S_RD_WAIT;
            end
          end
          rbd_pkg::OP_SET: begin
            if (!pos_ok) begin
              status_d = rbd_pkg::ST_RANGE;
            end else begin
              idx_a_d = li;
              st_d    = S_WRITE;
            end
          end
          rbd_pkg::OP_DELETE: begin
            if (!pos_ok) begin
              status_d = rbd_pkg::ST_RANGE;
            end else begin
              idx_a_d = li;
              if ((CW + 1)'(li) + (CW + 1)'(1) < (CW + 1)'(count_q)) begin
                st_d = S_DEL_RD;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
          end
          rbd_pkg::OP_REVERSE: begin
            if (count_q > CW'(1)) begin
              idx_a_d = '0;
              idx_b_d = count_q - CW'(1);
              st_d    = S_RV_RDA;
            end
          end
          rbd_pkg::OP_CLEAR: begin
            count_d = '0;
            head_d  = '0;
          end
          default: begin
            st_d = S_DONE;
          end
        endcase
      end
      S_WRITE: begin
        agu_off  = idx_a_q;
        mem_we_o = 1'b1;
        st_d     = S_DONE;
      end
      S_RD_WAIT: begin
        dout_d = mem_rdata_i;
        if (op_q == rbd_pkg::OP_POP_LEFT) begin
          agu_off = CW'(1);
          head_d  = agu_addr;
        end
        st_d = S_DONE;
      end
      S_DEL_RD: begin
        agu_off  = idx_a_q + CW'(1);
        mem_re_o = 1'b1;
        st_d     = S_DEL_WR;
      end
      S_DEL_WR: begin
        // shift the next element one place toward the head
        agu_off     = idx_a_q;
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        idx_a_d     = idx_a_q + CW'(1);
        if ((CW + 1)'(idx_a_q) + (CW + 1)'(2) < (CW + 1)'(count_q)) begin
          st_d = S_DEL_RD;
        end else begin
          count_d = count_q - CW'(1);
          st_d    = S_DONE;
        end
      end
      S_RV_RDA: begin
        agu_off  = idx_a_q;
        mem_re_o = 1'b1;
        st_d     = S_RV_RDB;
      end
      S_RV_RDB: begin
        agu_off  = idx_b_q;
        mem_re_o = 1'b1;
        tmp_d    = mem_rdata_i;
        st_d     = S_RV_WRA;
      end
      S_RV_WRA: begin
        agu_off     = idx_a_q;
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        st_d        = S_RV_WRB;
      end
      S_RV_WRB: begin
        agu_off     = idx_b_q;
        mem_we_o    = 1'b1;
        mem_wdata_o = tmp_q;
        idx_a_d     = idx_a_q + CW'(1);
        idx_b_d     = idx_b_q - CW'(1);
        if ((CW + 1)'(idx_a_q) + (CW + 1)'(2) < (CW + 1)'(idx_b_q)) begin
          st_d = S_RV_RDA;
        end else begin
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      status_q <= rbd_pkg::ST_OK;
    end else begin
      st_q     <= st_d;
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pos_q   <= pos_d;
    wdata_q <= wdata_d;
    dout_q  <= dout_d;
    idx_a_q <= idx_a_d;
    idx_b_q <= idx_b_d;
    tmp_q   <= tmp_d;
  end

  assign in_ready_o   = (st_q == S_IDLE);
  assign res_valid_o  = (st_q == S_DONE);
  assign res_data_o   = dout_q;
  assign res_status_o = status_q;
  assign res_occ_o    = count_q;
  assign mem_addr_o   = agu_addr;

  `RBD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
  `RBD_ASSERT_NOW(a_head_bound, 1'b1, (CW + 1)'(head_q) < (CW + 1)'(DEPTH))
  `RBD_ASSERT_NOW(a_rev_order, st_q == S_RV_RDA, idx_a_q < idx_b_q)
  `RBD_ASSERT_NOW(a_del_span, st_q == S_DEL_RD,
                  (CW + 1)'(idx_a_q) + (CW + 1)'(1) < (CW + 1)'(count_q))
  `RBD_ASSERT_NEXT(a_no_rw_clash, mem_we_o && mem_re_o, 1'b0)

endmodule

### src/ring_buffer_deque_unit.sv
// Top level of the ring buffer deque: config registers, sequencer, store, result register
`timescale 1ns / 1ps
// Double-ended queue on a ring store of DEPTH entries.
// in_i carries one operation item (opcode, signed position, data_in); out_o returns
// exactly one result item per operation (data_out, status, occupancy after it).
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, index 0 limit_enable, 1 max_length;
// write only while no operation is in flight.
// A delete moves each element between the deleted one and the tail one place toward
// the head; a reverse swaps element pairs from both ends inward.
// The store is single-port: every element move is a read followed by a write
// through the one shared address unit.
// Results sit in an output register, so a new item is taken while the last result
// waits. If the receiver stalls, the next operation completes internally and then
// holds until the register drains.
// Reset empties the deque (head and count zero), clears the limit and sets
// max_length to 64; the store contents are left as they are.
module ring_buffer_deque_unit #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rbd_in_if.sink                             in_i,
  rbd_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  rbd_pkg::cfg_t cfg_q;

  logic                         res_valid;
  logic                         res_ready;
  logic [DATA_WIDTH-1:0]        res_data;
  logic [rbd_pkg::STATUS_W-1:0] res_status;
  logic [CW-1:0]                res_occ;

  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                         out_valid_q;
  logic [DATA_WIDTH-1:0]        out_data_q;
  logic [rbd_pkg::STATUS_W-1:0] out_status_q;
  logic [CW-1:0]                out_occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_enable <= 1'b0;
      cfg_q.max_length   <= rbd_pkg::MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbd_pkg::REG_LIMIT_ENABLE: cfg_q.limit_enable <= cfg_data_i[0];
        rbd_pkg::REG_MAX_LENGTH:   cfg_q.max_length   <= cfg_data_i[rbd_pkg::MAXLEN_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  rbd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .opcode_i     (in_i.opcode),
    .position_i   (in_i.position),
    .data_in_i    (in_i.data_in),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_data_o   (res_data),
    .res_status_o (res_status),
    .res_occ_o    (res_occ),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  rbd_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // result register, refilled in the cycle it drains
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q   <= res_data;
      out_status_q <= res_status;
      out_occ_q    <= res_occ;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.data_out  = out_data_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the ring buffer deque: directed, boundary and random operations
`timescale 1ns / 1ps
module testbench;
  import rbd_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 400;

  // opcodes the block treats as no operation
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    status_e               status;
    logic [MAXLEN_W-1:0]   occ;
  } deque_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rbd_in_if  #(.DATA_WIDTH(DATA_WIDTH))                deque_req ();
  rbd_out_if #(.DATA_WIDTH(DATA_WIDTH), .OCC_WIDTH(7)) deque_rsp ();

  ring_buffer_deque_unit #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (deque_req),
    .out_o     (deque_rsp),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // shadow copy of the deque
  logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
  logic [5:0]            shadow_head;
  logic [MAXLEN_W-1:0]   shadow_count;
  logic                  shadow_limit_en;
  logic [MAXLEN_W-1:0]   shadow_max_len;

  deque_result_t pending_results[$];
  int            err_count;
  int unsigned   snd_idle_pct;
  int unsigned   rcv_idle_pct;
  int unsigned   rx_hold_len;
  int unsigned   stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [5:0] slot_of(int idx);
    return shadow_head + 6'(idx);
  endfunction

  // applies one operation to the shadow deque and returns what the block must answer
  function automatic deque_result_t deque_apply_op(logic [OPCODE_W-1:0] op,
                                                  logic signed [POS_W-1:0] pos,
                                                  logic [DATA_WIDTH-1:0] din);
    deque_result_t         res;
    int                    cnt;
    int                    lim;
    int                    li;
    int                    a;
    int                    b;
    bit                    in_range;
    logic [DATA_WIDTH-1:0] tmp;
    res.data   = '0;
    res.status = ST_OK;
    cnt        = int'(shadow_count);
    lim        = (shadow_max_len > DEPTH) ? DEPTH : int'(shadow_max_len);
    in_range   = (int'(pos) < cnt) && (int'(pos) >= -cnt);
    li         = (int'(pos) < 0) ? int'(pos) + cnt : int'(pos);
    case (op)
      OP_APPEND, OP_PREPEND: begin
        if (shadow_limit_en && cnt >= lim) begin
          // at the limit: far end is dropped, count stays put (zero limit stores nothing)
          if (cnt != 0) begin
            if (op == OP_APPEND) begin
              shadow_head = shadow_head + 6'd1;
              shadow_mem[slot_of(cnt - 1)] = din;
            end else begin
              shadow_head = shadow_head - 6'd1;
              shadow_mem[shadow_head] = din;
            end
          end
        end else if (cnt >= DEPTH) begin
          res.status = ST_FULL;
        end else if (op == OP_APPEND) begin
          shadow_mem[slot_of(cnt)] = din;
          shadow_count = shadow_count + 7'd1;
        end else begin
          shadow_head = shadow_head - 6'd1;
          shadow_mem[shadow_head] = din;
          shadow_count = shadow_count + 7'd1;
        end
      end
      OP_POP_RIGHT: begin
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count = shadow_count - 7'd1;
          res.data = shadow_mem[slot_of(cnt - 1)];
        end
      end
      OP_POP_LEFT: begin
        if (cnt == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = shadow_mem[shadow_head];
          shadow_head = shadow_head + 6'd1;
          shadow_count = shadow_count - 7'd1;
        end
      end
      OP_GET, OP_SET, OP_DELETE: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else if (op == OP_GET) begin
          res.data = shadow_mem[slot_of(li)];
        end else if (op == OP_SET) begin
          shadow_mem[slot_of(li)] = din;
        end else begin
          for (int i = li; i + 1 < cnt; i++) begin
            shadow_mem[slot_of(i)] = shadow_mem[slot_of(i + 1)];
          end
          shadow_count = shadow_count - 7'd1;
        end
      end
      OP_REVERSE: begin
        a = 0;
        b = cnt - 1;
        while (a < b) begin
          tmp = shadow_mem[slot_of(a)];
          shadow_mem[slot_of(a)] = shadow_mem[slot_of(b)];
          shadow_mem[slot_of(b)] = tmp;
          a++;
          b--;
        end
      end
      OP_CLEAR: begin
        shadow_count = '0;
        shadow_head  = '0;
      end
      default: begin
      end
    endcase
    res.occ = shadow_count;
    return res;
  endfunction

  // prediction at every accepted request item
  always @(posedge clk_i) begin
    if (rst_ni && deque_req.valid && deque_req.ready) begin
      pending_results.push_back(deque_apply_op(deque_req.opcode, deque_req.position,
                                               deque_req.data_in));
    end
  end

  // result checker
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && deque_rsp.valid && deque_rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item: data %h status %0d occupancy %0d", $time,
                 deque_rsp.data_out, deque_rsp.status, deque_rsp.occupancy);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (deque_rsp.data_out !== want.data) begin
          $display("%0t: data_out mismatch: expected %h, actual %h", $time, want.data,
                   deque_rsp.data_out);
          err_count++;
        end
        if (deque_rsp.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status,
                   deque_rsp.status);
          err_count++;
        end
        if (deque_rsp.occupancy !== want.occ) begin
          $display("%0t: occupancy mismatch: expected %0d, actual %0d", $time, want.occ,
                   deque_rsp.occupancy);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((deque_req.valid && deque_req.ready) || (deque_rsp.valid && deque_rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random back-pressure, or a long hold when one is requested
  initial begin
    deque_rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len > 0) begin
        deque_rsp.ready = 1'b0;
        rx_hold_len--;
      end else begin
        deque_rsp.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // entered and left at a falling edge; valid stays high for a back-to-back item
  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic signed [POS_W-1:0] pos,
                         input logic [DATA_WIDTH-1:0] din);
    while ($urandom_range(99) < snd_idle_pct) begin
      deque_req.valid = 1'b0;
      @(negedge clk_i);
    end
    deque_req.valid    = 1'b1;
    deque_req.opcode   = op;
    deque_req.position = pos;
    deque_req.data_in  = din;
    @(posedge clk_i);
    while (!deque_req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    deque_req.valid = 1'b0;
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == REG_LIMIT_ENABLE) begin
      shadow_limit_en = val[0];
    end else begin
      shadow_max_len = val;
    end
  endtask

  // mostly a position inside the current contents, from the head or the tail; else any
  function automatic logic signed [POS_W-1:0] pick_position();
    int cnt;
    int li;
    cnt = int'(shadow_count);
    if (cnt == 0 || $urandom_range(99) < 15) begin
      return POS_W'($urandom_range(127));
    end
    li = $urandom_range(cnt - 1);
    return ($urandom_range(1) == 1) ? POS_W'(li) : POS_W'(li - cnt);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_data();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_basic_ops();
    send_op(OP_POP_RIGHT, 0, 0);
    send_op(OP_POP_LEFT, 0, 0);
    send_op(OP_GET, 0, 0);
    send_op(OP_REVERSE, 0, 0);
    send_op(OP_CLEAR, 0, 0);
    send_op(OP_APPEND, 0, 32'hFFFF_FFFF);
    send_op(OP_PREPEND, 0, 32'h0000_0000);
    send_op(OP_APPEND, -1, 32'hA5A5_5A5A);
    send_op(OP_GET, -1, 0);
    send_op(OP_GET, -3, 0);
    send_op(OP_GET, -4, 0);
    send_op(OP_GET, 63, 0);
    send_op(OP_GET, -64, 0);
    send_op(OP_SET, 1, 32'h1234_5678);
    send_op(OP_SET, 3, 32'hDEAD_BEEF);
    send_op(OP_DELETE, 0, 32'hFFFF_FFFF);
    send_op(OP_REVERSE, 0, 0);
    send_op(OP_POP_LEFT, 0, 0);
    send_op(OP_POP_RIGHT, 0, 0);
    send_op(OP_SPARE_LO, 5, 32'h5555_5555);
    send_op(OP_SPARE_HI, -5, 32'hAAAA_AAAA);
    send_op(OP_DELETE, -64, 0);
    send_op(OP_CLEAR, 0, 0);
  endtask

  // no limit: fill the ring, push into it, then the longest reverse and delete
  task automatic test_full_ring();
    write_reg(REG_LIMIT_ENABLE, 7'd0);
    for (int i = 0; i < DEPTH; i++) send_op(OP_APPEND, 0, $urandom());
    send_op(OP_APPEND, 0, 32'h0BAD_0BAD);
    send_op(OP_PREPEND, 0, 32'h0BAD_0BAD);
    send_op(OP_REVERSE, 0, 0);
    send_op(OP_DELETE, 0, 0);
    send_op(OP_GET, -63, 0);
    send_op(OP_GET, 62, 0);
    send_op(OP_PREPEND, 0, 32'hCAFE_F00D);
    send_op(OP_POP_RIGHT, 0, 0);
    send_op(OP_CLEAR, 0, 0);
  endtask

  task automatic test_length_limit();
    // only bit 0 of a wide write is kept
    write_reg(REG_LIMIT_ENABLE, 7'h7F);
    write_reg(REG_MAX_LENGTH, 7'd0);
    send_op(OP_APPEND, 0, 32'h1111_1111);
    send_op(OP_PREPEND, 0, 32'h2222_2222);
    // limit above the ring size acts as the ring size
    write_reg(REG_MAX_LENGTH, 7'd127);
    for (int i = 0; i < DEPTH + 2; i++) send_op(OP_APPEND, 0, $urandom());
    send_op(OP_PREPEND, 0, 32'h3333_3333);
    send_op(OP_GET, 0, 0);
    send_op(OP_GET, -1, 0);
    // limit lowered under the count: pushes keep the count where it is
    write_reg(REG_MAX_LENGTH, 7'd3);
    send_op(OP_APPEND, 0, 32'h4444_4444);
    send_op(OP_PREPEND, 0, 32'h5555_5555);
    send_op(OP_POP_LEFT, 0, 0);
    send_op(OP_POP_RIGHT, 0, 0);
    write_reg(REG_LIMIT_ENABLE, 7'h7E);
    send_op(OP_APPEND, 0, 32'h6666_6666);
    send_op(OP_CLEAR, 0, 0);
    write_reg(REG_MAX_LENGTH, MAX_LENGTH_RST);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned           push_pct;
    int unsigned           sel;
    logic [OPCODE_W-1:0]   op;
    logic signed [POS_W-1:0] pos;
    for (int k = 0; k < n_items; k++) begin
      // keep the fill level moving through the whole range
      push_pct = (shadow_count > 52) ? 20 : ((shadow_count < 8) ? 55 : 35);
      pos = POS_W'($urandom_range(127));
      if ($urandom_range(99) < push_pct) begin
        op = ($urandom_range(1) == 1) ? OP_APPEND : OP_PREPEND;
      end else begin
        sel = $urandom_range(99);
        if (sel < 20) begin
          op = ($urandom_range(1) == 1) ? OP_POP_RIGHT : OP_POP_LEFT;
        end else if (sel < 60) begin
          op = ($urandom_range(1) == 1) ? OP_GET : OP_SET;
          pos = pick_position();
        end else if (sel < 72) begin
          op = OP_DELETE;
          pos = pick_position();
        end else if (sel < 77) begin
          op = OP_REVERSE;
        end else if (sel < 79) begin
          op = OP_CLEAR;
        end else if (sel < 85) begin
          op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else begin
          op = OPCODE_W'($urandom_range(15));
        end
      end
      send_op(op, pos, pick_data());
    end
  endtask

  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      case (chunk)
        0: begin
          write_reg(REG_LIMIT_ENABLE, 7'd0);
          write_reg(REG_MAX_LENGTH, CFG_DATA_W'($urandom_range(127)));
        end
        1: begin
          write_reg(REG_MAX_LENGTH, CFG_DATA_W'($urandom_range(1, 20)));
          write_reg(REG_LIMIT_ENABLE, 7'd1);
        end
        2: write_reg(REG_MAX_LENGTH, CFG_DATA_W'($urandom_range(21, 127)));
        default: write_reg(REG_LIMIT_ENABLE, 7'd0);
      endcase
      run_random(PHASE_ITEMS / 4);
    end
  endtask

  // receiver stops for a long stretch while items keep coming, then the sender waits it out
  task automatic test_back_pressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    wait_drained();
    @(posedge clk_i);
    rx_hold_len = HOLD_CYCLES;
    @(negedge clk_i);
    for (int i = 0; i < 16; i++) begin
      send_op((i % 3 == 2) ? OP_POP_LEFT : OP_APPEND, 0, $urandom());
    end
    wait_drained();
    send_op(OP_REVERSE, 0, 0);
    send_op(OP_GET, -1, 0);
    send_op(OP_CLEAR, 0, 0);
  endtask

  initial begin
    deque_req.valid    = 1'b0;
    deque_req.opcode   = '0;
    deque_req.position = '0;
    deque_req.data_in  = '0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    rst_ni             = 1'b0;
    err_count          = 0;
    stall_cycles       = 0;
    rx_hold_len        = 0;
    snd_idle_pct       = 19;
    rcv_idle_pct       = 73;
    shadow_head        = '0;
    shadow_count       = '0;
    shadow_limit_en    = 1'b0;
    shadow_max_len     = MAX_LENGTH_RST;
    for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_ops();
    test_full_ring();
    test_length_limit();
    test_random_phase(19, 73);
    test_random_phase(73, 19);
    test_random_phase(0, 0);
    test_back_pressure();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/rbd_pkg.sv
src/rbd_if.sv
src/rbd_mem.sv
src/rbd_agu.sv
src/rbd_ctrl.sv
src/ring_buffer_deque_unit.sv
tb/sv/testbench.sv
